>>> src/kfls_pkg.sv
`default_nettype none
package kfls_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SEL_ZERO  = 3'd0,
        SEL_FIRST = 3'd1,
        SEL_LAST  = 3'd2,
        SEL_BLEND = 3'd3
    } rsel_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        logic    rd_pair;
        logic    div_start;
        logic    mul_start;
        logic    set_result;
        rsel_t   rsel;
        status_t status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic t_le_first;
        logic seg_hit;
        logic div_done;
        logic mul_done;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> src/kfls_ctrl.sv
`default_nettype none
module kfls_ctrl #(
    parameter int AW       = 6,
    parameter int MAX_KEYS = 64
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [1:0]            s_command,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [AW:0]           key_count,
    output logic                  wr_en,
    output logic [AW-1:0]         rd_addr,
    output kfls_pkg::dp_cmd_t     cmd,
    input  kfls_pkg::dp_stat_t    stat
);
    import kfls_pkg::*;

    localparam logic [AW:0] MAXK = (AW+1)'(MAX_KEYS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_CHK0  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_MUL   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [AW:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        mv_reg, mv_next;

    assign key_count = count_reg;
    assign m_valid   = mv_reg;
    assign s_ready   = (state_reg == S_IDLE) && (!mv_reg || m_ready);
    assign rd_addr   = idx_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        mv_next    = mv_reg;
        wr_en      = 1'b0;
        cmd        = '0;
        cmd.rsel   = SEL_ZERO;
        cmd.status = ST_OK;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_in = 1'b1;
                    case (cmd_t'(s_command))
                        CMD_CLEAR: begin
                            count_next = '0;
                            cmd.set_result = 1'b1;
                            mv_next = 1'b1;
                        end
                        CMD_APPEND: begin
                            cmd.set_result = 1'b1;
                            mv_next = 1'b1;
                            if (count_reg < MAXK) begin
                                wr_en = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                cmd.status = ST_FULL;
                            end
                        end
                        CMD_SAMPLE: begin
                            if (count_reg == '0) begin
                                cmd.set_result = 1'b1;
                                cmd.status = ST_EMPTY;
                                mv_next = 1'b1;
                            end else begin
                                idx_next = '0;
                                state_next = S_FIRST;
                            end
                        end
                        default: begin
                            cmd.set_result = 1'b1;
                            mv_next = 1'b1;
                        end
                    endcase
                end
            end
            S_FIRST: begin
                cmd.rd_en = 1'b1;
                state_next = S_CHK0;
            end
            S_CHK0: begin
                if (count_reg == (AW+1)'(1) || stat.t_le_first) begin
                    cmd.set_result = 1'b1;
                    cmd.rsel = SEL_FIRST;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_en = 1'b1;
                cmd.rd_pair = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (stat.seg_hit) begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end else if ({1'b0, idx_reg} + (AW+1)'(2) >= count_reg) begin
                    cmd.set_result = 1'b1;
                    cmd.rsel = SEL_LAST;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.mul_start = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (stat.mul_done) begin
                    cmd.set_result = 1'b1;
                    cmd.rsel = SEL_BLEND;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            mv_reg    <= mv_next;
        end
    end
endmodule
`default_nettype wire

>>> src/kfls_dp.sv
`default_nettype none
module kfls_dp #(
    parameter int AW = 6
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire signed [31:0]      s_time_value,
    input  wire signed [31:0]      s_value_x,
    input  wire signed [31:0]      s_value_y,
    input  wire signed [31:0]      s_value_z,
    input  wire  [AW:0]            key_count,
    input  wire                    wr_en,
    input  wire  [AW-1:0]          rd_addr,
    input  kfls_pkg::dp_cmd_t      cmd,
    output kfls_pkg::dp_stat_t     stat,
    output logic signed [31:0]     m_result_x,
    output logic signed [31:0]     m_result_y,
    output logic signed [31:0]     m_result_z,
    output logic [1:0]             m_status
);
    import kfls_pkg::*;

    localparam int DEPTH = 1 << AW;

    // one row: time, x, y, z
    logic [127:0] mem_a [DEPTH];
    logic [127:0] mem_b [DEPTH];
    logic [127:0] ra_reg, rb_reg;
    logic signed [31:0] t_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[key_count[AW-1:0]] <= {s_time_value, s_value_x, s_value_y, s_value_z};
            mem_b[key_count[AW-1:0]] <= {s_time_value, s_value_x, s_value_y, s_value_z};
        end
        if (cmd.rd_en) begin
            ra_reg <= mem_a[rd_addr];
            rb_reg <= mem_b[cmd.rd_pair ? rd_addr + 1'b1 : rd_addr];
        end
        if (cmd.load_in) t_reg <= s_time_value;
    end

    logic signed [31:0] t0, t1;
    assign t0 = ra_reg[127:96];
    assign t1 = rb_reg[127:96];
    assign stat.t_le_first = t_reg <= t0;
    assign stat.seg_hit    = (t0 <= t_reg) && (t_reg <= t1);

    // restoring divider: (num << 16) / den, quotient up to 17 bits
    logic [32:0] den_reg, rem_reg;
    logic [48:0] num_reg;
    logic [16:0] q_reg;
    logic [5:0]  dcnt_reg;
    logic        dbusy_reg, ddone_reg;
    logic [33:0] trial;
    logic [32:0] rem_sh;

    assign rem_sh = {rem_reg[31:0], num_reg[48]};
    assign trial  = {1'b0, rem_sh} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
        end else begin
            ddone_reg <= 1'b0;
            if (cmd.div_start) begin
                dbusy_reg <= (t1 != t0);
                ddone_reg <= (t1 == t0);
                den_reg   <= 33'(34'(signed'(t1)) - 34'(signed'(t0)));
                num_reg   <= {33'(34'(t_reg) - 34'(t0)), 16'd0};
                rem_reg   <= '0;
                q_reg     <= '0;
                dcnt_reg  <= 6'd49;
            end else if (dbusy_reg) begin
                num_reg <= {num_reg[47:0], 1'b0};
                if (!trial[33]) begin
                    rem_reg <= trial[32:0];
                    q_reg   <= {q_reg[15:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[15:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == 6'd1) begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end
    assign stat.div_done = ddone_reg;

    // blend one component per cycle: x, then y, then z
    logic [1:0]         mcnt_reg;
    logic               mbusy_reg, mdone_reg;
    logic signed [31:0] a_sel, b_sel;
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [34:0] q;
    logic signed [31:0] bl;
    logic signed [31:0] bx_reg, by_reg, bz_reg;

    always_comb begin
        case (mcnt_reg)
            2'd0:    begin a_sel = ra_reg[95:64]; b_sel = rb_reg[95:64]; end
            2'd1:    begin a_sel = ra_reg[63:32]; b_sel = rb_reg[63:32]; end
            default: begin a_sel = ra_reg[31:0];  b_sel = rb_reg[31:0];  end
        endcase
        diff = 33'(b_sel) - 33'(a_sel);
        prod = 51'(diff) * signed'({34'd0, q_reg});
        q    = 35'(prod >>> 16);
        bl   = 32'(35'(a_sel) + q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else begin
            mdone_reg <= 1'b0;
            if (cmd.mul_start) begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end else if (mbusy_reg) begin
                case (mcnt_reg)
                    2'd0:    bx_reg <= bl;
                    2'd1:    by_reg <= bl;
                    default: bz_reg <= bl;
                endcase
                mcnt_reg <= mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd2) begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
        end
    end
    assign stat.mul_done = mdone_reg;

    always_ff @(posedge aclk) begin
        if (cmd.set_result) begin
            m_status <= cmd.status;
            unique case (cmd.rsel)
                SEL_FIRST: begin
                    m_result_x <= ra_reg[95:64];
                    m_result_y <= ra_reg[63:32];
                    m_result_z <= ra_reg[31:0];
                end
                SEL_LAST: begin
                    m_result_x <= rb_reg[95:64];
                    m_result_y <= rb_reg[63:32];
                    m_result_z <= rb_reg[31:0];
                end
                SEL_BLEND: begin
                    m_result_x <= bx_reg;
                    m_result_y <= by_reg;
                    m_result_z <= bz_reg;
                end
                default: begin
                    m_result_x <= '0;
                    m_result_y <= '0;
                    m_result_z <= '0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/keyframe_linear_sampler.sv
`default_nettype none
// Keyframe table with linear sampling. Append, clear and unused commands,
// and a sample of an empty table, return their word in the cycle after
// acceptance. Otherwise a sample reads the first key, then scans segment by
// segment through the dual-read key memory; a hit runs a bit-serial divider
// and then a blend of the two keys of the segment.
// One word is in flight at a time.
module keyframe_linear_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [1:0]         s_command,
    input  wire  signed [31:0] s_time_value,
    input  wire  signed [31:0] s_value_x,
    input  wire  signed [31:0] s_value_y,
    input  wire  signed [31:0] s_value_z,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_result_x,
    output logic signed [31:0] m_result_y,
    output logic signed [31:0] m_result_z,
    output logic [1:0]         m_status
);
    import kfls_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);

    logic [AW:0]   key_count;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    dp_cmd_t       cmd;
    dp_stat_t      stat;

    kfls_ctrl #(.AW(AW), .MAX_KEYS(MAX_KEYS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .m_valid(m_valid), .m_ready(m_ready),
        .key_count(key_count), .wr_en(wr_en), .rd_addr(rd_addr),
        .cmd(cmd), .stat(stat)
    );

    kfls_dp #(.AW(AW)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .s_time_value(s_time_value), .s_value_x(s_value_x),
        .s_value_y(s_value_y), .s_value_z(s_value_z),
        .key_count(key_count), .wr_en(wr_en), .rd_addr(rd_addr),
        .cmd(cmd), .stat(stat),
        .m_result_x(m_result_x), .m_result_y(m_result_y),
        .m_result_z(m_result_z), .m_status(m_status)
    );
endmodule
`default_nettype wire
